>>> rtl/core/modbus_request_validator_unit_assert.svh
// Assertion macros used by the checker file of the request validator.
`ifndef MODBUS_REQUEST_VALIDATOR_UNIT_ASSERT_SVH
`define MODBUS_REQUEST_VALIDATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MRV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MRV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/mrv_pkg.sv
package mrv_pkg;

	// Status codes returned for one request item.
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_SERVER = 3'd1;
	localparam logic [2:0] ST_FUNC   = 3'd2;
	localparam logic [2:0] ST_COUNT  = 3'd3;
	localparam logic [2:0] ST_LIMIT  = 3'd4;
	localparam logic [2:0] ST_DATA   = 3'd5;

	// Request shapes.
	localparam logic [2:0] SHAPE_NONE  = 3'd0;
	localparam logic [2:0] SHAPE_ONE   = 3'd1;
	localparam logic [2:0] SHAPE_TWO   = 3'd2;
	localparam logic [2:0] SHAPE_THREE = 3'd3;
	localparam logic [2:0] SHAPE_WORDS = 3'd4;
	localparam logic [2:0] SHAPE_BYTES = 3'd5;
	localparam logic [2:0] SHAPE_RAW   = 3'd6;
	localparam logic [2:0] SHAPE_SPARE = 3'd7;

	// Server identifier and function code limits.
	localparam logic [7:0] SERVER_ID_MAX = 8'd247;
	localparam logic [7:0] FC_MAX        = 8'd127;

	// Function codes that are rejected outright.
	localparam logic [7:0] FC_NONE    = 8'h00;
	localparam logic [7:0] FC_RSVD_09 = 8'h09;
	localparam logic [7:0] FC_RSVD_0A = 8'h0a;
	localparam logic [7:0] FC_RSVD_0D = 8'h0d;
	localparam logic [7:0] FC_RSVD_0E = 8'h0e;
	localparam logic [7:0] FC_RSVD_12 = 8'h12;
	localparam logic [7:0] FC_RSVD_13 = 8'h13;

	// Function codes with special handling.
	localparam logic [7:0] FC_READ_COILS      = 8'h01;
	localparam logic [7:0] FC_READ_DISCRETE   = 8'h02;
	localparam logic [7:0] FC_READ_HOLDING    = 8'h03;
	localparam logic [7:0] FC_READ_INPUT      = 8'h04;
	localparam logic [7:0] FC_WRITE_COIL      = 8'h05;
	localparam logic [7:0] FC_WRITE_REGISTER  = 8'h06;
	localparam logic [7:0] FC_READ_EXCEPTION  = 8'h07;
	localparam logic [7:0] FC_DIAGNOSTICS     = 8'h08;
	localparam logic [7:0] FC_COMM_COUNTER    = 8'h0b;
	localparam logic [7:0] FC_COMM_LOG        = 8'h0c;
	localparam logic [7:0] FC_WRITE_COILS     = 8'h0f;
	localparam logic [7:0] FC_WRITE_REGISTERS = 8'h10;
	localparam logic [7:0] FC_REPORT_SERVER   = 8'h11;
	localparam logic [7:0] FC_FILE_READ       = 8'h14;
	localparam logic [7:0] FC_MASK_WRITE      = 8'h16;
	localparam logic [7:0] FC_READ_FIFO       = 8'h18;
	localparam logic [7:0] FC_ENCAP           = 8'h2b;

	// Quantity limits.
	localparam logic [15:0] QTY_BITS_MAX      = 16'h07d0;
	localparam logic [15:0] QTY_REGS_MAX      = 16'h007d;
	localparam logic [15:0] COIL_ON           = 16'hff00;
	localparam logic [15:0] QTY_WRITE_REG_MAX = 16'h007b;
	localparam logic [15:0] QTY_WRITE_BIT_MAX = 16'h07b0;

endpackage

>>> rtl/core/modbus_request_validator_unit.sv
// Modbus request parameter check, one status item per request item.
// Each request item passes through the input register, then the result
// register, which holds its status item for the output; a stall on the
// output can hold the status item back.
// Throughput: one request item per cycle when the output is not stalled.
// Reset (arst_n low, asynchronous) empties both pipeline stages at once.
module modbus_request_validator_unit
	import mrv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [7:0]  server_id,
	input  logic [7:0]  function_code,
	input  logic [15:0] quantity,
	input  logic [7:0]  byte_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status
);

	// Stage one holds the request item as it arrived.
	logic        valid_s1;
	logic [2:0]  func_s1;
	logic [7:0]  server_id_s1;
	logic [7:0]  function_code_s1;
	logic [15:0] quantity_s1;
	logic [7:0]  byte_count_s1;

	// Stage two holds the finished status item.
	logic        valid_s2;
	logic [2:0]  status_s2;

	logic        load_s2;
	logic        load_s1;
	logic [2:0]  status_next;

	// The result register takes a new item whenever it is empty or drained
	// in this cycle; stage one moves on whenever the result register takes it.
	// So the input only stalls when both stages are full and the output stalls.
	assign load_s2  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !load_s2;
	assign load_s1  = !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			func_s1          <= func;
			server_id_s1     <= server_id;
			function_code_s1 <= function_code;
			quantity_s1      <= quantity;
			byte_count_s1    <= byte_count;
		end
	end

	// Decode of the function code: the illegal codes, the codes whose
	// parameter count is known, and the codes each shape carries.
	logic fc_illegal;
	logic fc_known;
	logic shape_ok;
	logic qty_zero;
	logic [11:0] qty_round;
	logic [8:0]  bytes_for_bits;
	logic [7:0]  bytes_for_regs;

	always_comb begin
		fc_illegal = (function_code_s1 == FC_NONE) || (function_code_s1 == FC_RSVD_09) ||
			(function_code_s1 == FC_RSVD_0A) || (function_code_s1 == FC_RSVD_0D) ||
			(function_code_s1 == FC_RSVD_0E) || (function_code_s1 == FC_RSVD_12) ||
			(function_code_s1 == FC_RSVD_13) || (function_code_s1 > FC_MAX);

		fc_known = ((function_code_s1 >= FC_READ_COILS) &&
				(function_code_s1 <= FC_DIAGNOSTICS)) ||
			((function_code_s1 >= FC_FILE_READ) && (function_code_s1 <= FC_READ_FIFO)) ||
			(function_code_s1 == FC_COMM_COUNTER) || (function_code_s1 == FC_COMM_LOG) ||
			(function_code_s1 == FC_WRITE_COILS) || (function_code_s1 == FC_WRITE_REGISTERS) ||
			(function_code_s1 == FC_REPORT_SERVER) || (function_code_s1 == FC_ENCAP);

		case (func_s1)
			SHAPE_NONE: begin
				shape_ok = (function_code_s1 == FC_READ_EXCEPTION) ||
					(function_code_s1 == FC_COMM_COUNTER) ||
					(function_code_s1 == FC_COMM_LOG) ||
					(function_code_s1 == FC_REPORT_SERVER);
			end
			SHAPE_ONE:   shape_ok = (function_code_s1 == FC_READ_FIFO);
			SHAPE_TWO: begin
				shape_ok = (function_code_s1 >= FC_READ_COILS) &&
					(function_code_s1 <= FC_WRITE_REGISTER);
			end
			SHAPE_THREE: shape_ok = (function_code_s1 == FC_MASK_WRITE);
			SHAPE_WORDS: shape_ok = (function_code_s1 == FC_WRITE_REGISTERS);
			SHAPE_BYTES: shape_ok = (function_code_s1 == FC_WRITE_COILS);
			default:     shape_ok = 1'b1;
		endcase

		qty_zero = (quantity_s1 == 16'd0);
		// Byte counts are only compared once the quantity passed its limit,
		// so the low quantity bits are enough to form them.
		bytes_for_regs = {quantity_s1[6:0], 1'b0};
		qty_round      = {1'b0, quantity_s1[10:0]} + 12'd7;
		bytes_for_bits = qty_round[11:3];
	end

	// Priority: server, function, parameter count, then the shape limits.
	always_comb begin
		status_next = ST_OK;
		if ((server_id_s1 == 8'd0) || (server_id_s1 > SERVER_ID_MAX)) begin
			status_next = ST_SERVER;
		end else if (fc_illegal) begin
			status_next = ST_FUNC;
		end else if (func_s1 > SHAPE_BYTES) begin
			status_next = ST_OK;
		end else if (!fc_known) begin
			status_next = ST_OK;
		end else if (!shape_ok) begin
			status_next = ST_COUNT;
		end else if (func_s1 == SHAPE_TWO) begin
			if ((function_code_s1 == FC_READ_COILS) ||
					(function_code_s1 == FC_READ_DISCRETE)) begin
				if (qty_zero || (quantity_s1 > QTY_BITS_MAX)) status_next = ST_LIMIT;
			end else if ((function_code_s1 == FC_READ_HOLDING) ||
					(function_code_s1 == FC_READ_INPUT)) begin
				if (qty_zero || (quantity_s1 > QTY_REGS_MAX)) status_next = ST_LIMIT;
			end else if (function_code_s1 == FC_WRITE_COIL) begin
				if (!qty_zero && (quantity_s1 != COIL_ON)) status_next = ST_LIMIT;
			end
		end else if (func_s1 == SHAPE_WORDS) begin
			if (qty_zero || (quantity_s1 > QTY_WRITE_REG_MAX)) begin
				status_next = ST_LIMIT;
			end else if (byte_count_s1 != bytes_for_regs) begin
				status_next = ST_DATA;
			end
		end else if (func_s1 == SHAPE_BYTES) begin
			if (qty_zero || (quantity_s1 > QTY_WRITE_BIT_MAX)) begin
				status_next = ST_LIMIT;
			end else if ({1'b0, byte_count_s1} != bytes_for_bits) begin
				status_next = ST_DATA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			status_s2 <= status_next;
		end
	end

	assign out_valid = valid_s2;
	assign status    = status_s2;

endmodule

>>> rtl/core/mrv_checker.sv
`include "modbus_request_validator_unit_assert.svh"

module mrv_checker
	import mrv_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] status
);

	// A stalled result stays put.
	`MRV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status), "stalled status item changed")

	// Only the six defined status codes ever leave the block.
	`MRV_ASSERT_NOW(a_status_range, out_valid, status <= ST_DATA, "status code out of range")

	// The input stalls only while a finished result is held back downstream.
	`MRV_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a blocked result")

endmodule

bind modbus_request_validator_unit mrv_checker u_mrv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status)
);

>>> verif/modbus_request_validator_unit_checker.sv
`timescale 1ns / 1ps

module modbus_request_validator_unit_checker
	import mrv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  func,
	input  logic [7:0]  server_id,
	input  logic [7:0]  function_code,
	input  logic [15:0] quantity,
	input  logic [7:0]  byte_count,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [2:0]  shape;
		logic [7:0]  sid;
		logic [7:0]  fc;
		logic [15:0] qty;
		logic [7:0]  cnt;
		logic [2:0]  status;
	} status_entry_t;

	status_entry_t status_due[$];
	status_entry_t oldest;
	status_entry_t incoming;

	function automatic logic fc_illegal(input logic [7:0] fc);
		case (fc)
			FC_NONE, FC_RSVD_09, FC_RSVD_0A, FC_RSVD_0D, FC_RSVD_0E, FC_RSVD_12,
			FC_RSVD_13: return 1'b1;
			default: return fc > FC_MAX;
		endcase
	endfunction

	function automatic logic fc_known(input logic [7:0] fc);
		if (fc >= FC_READ_COILS && fc <= FC_DIAGNOSTICS)
			return 1'b1;
		if (fc >= FC_FILE_READ && fc <= FC_READ_FIFO)
			return 1'b1;
		case (fc)
			FC_COMM_COUNTER, FC_COMM_LOG, FC_WRITE_COILS, FC_WRITE_REGISTERS,
			FC_REPORT_SERVER, FC_ENCAP: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic shape_fits(input logic [2:0] shape, input logic [7:0] fc);
		case (shape)
			SHAPE_NONE: return fc == FC_READ_EXCEPTION || fc == FC_COMM_COUNTER ||
				fc == FC_COMM_LOG || fc == FC_REPORT_SERVER;
			SHAPE_ONE: return fc == FC_READ_FIFO;
			SHAPE_TWO: return fc >= FC_READ_COILS && fc <= FC_WRITE_REGISTER;
			SHAPE_THREE: return fc == FC_MASK_WRITE;
			SHAPE_WORDS: return fc == FC_WRITE_REGISTERS;
			SHAPE_BYTES: return fc == FC_WRITE_COILS;
			default: return 1'b1;
		endcase
	endfunction

	function automatic logic [2:0] request_status(input logic [2:0] shape,
		input logic [7:0] sid, input logic [7:0] fc, input logic [15:0] qty,
		input logic [7:0] cnt);
		logic [16:0] word_bytes;
		logic [16:0] coil_bytes;
		word_bytes = {1'b0, qty} << 1;
		coil_bytes = ({1'b0, qty} + 17'd7) >> 3;
		if (sid == 8'd0 || sid > SERVER_ID_MAX)
			return ST_SERVER;
		if (fc_illegal(fc))
			return ST_FUNC;
		if (shape >= SHAPE_RAW || !fc_known(fc))
			return ST_OK;
		if (!shape_fits(shape, fc))
			return ST_COUNT;
		case (shape)
			SHAPE_TWO: begin
				if (fc == FC_READ_COILS || fc == FC_READ_DISCRETE) begin
					if (qty == 16'd0 || qty > QTY_BITS_MAX)
						return ST_LIMIT;
				end else if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT) begin
					if (qty == 16'd0 || qty > QTY_REGS_MAX)
						return ST_LIMIT;
				end else if (fc == FC_WRITE_COIL) begin
					if (qty != 16'd0 && qty != COIL_ON)
						return ST_LIMIT;
				end
				return ST_OK;
			end
			SHAPE_WORDS: begin
				if (qty == 16'd0 || qty > QTY_WRITE_REG_MAX)
					return ST_LIMIT;
				return (word_bytes == {9'd0, cnt}) ? ST_OK : ST_DATA;
			end
			SHAPE_BYTES: begin
				if (qty == 16'd0 || qty > QTY_WRITE_BIT_MAX)
					return ST_LIMIT;
				return (coil_bytes == {9'd0, cnt}) ? ST_OK : ST_DATA;
			end
			default: return ST_OK;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input status_entry_t req,
		input logic [2:0] got);
		$display("%0t: %s: func=%0d sid=%0d fc=0x%02h qty=0x%04h cnt=%0d exp=%0d got=%0d",
			$time, what, req.shape, req.sid, req.fc, req.qty, req.cnt, req.status, got);
		fail_count = fail_count + 1;
	endtask

	// Outputs are read before the block's own updates at this edge, so the
	// values seen are the ones that the handshake moved.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (status_due.size() == 0) begin
					oldest = '0;
					report_mismatch("status item with no request waiting", oldest, status);
				end else begin
					oldest = status_due.pop_front();
					if (status !== oldest.status)
						report_mismatch("wrong status", oldest, status);
				end
			end
			if (in_valid && !in_stall) begin
				incoming.shape = func;
				incoming.sid = server_id;
				incoming.fc = function_code;
				incoming.qty = quantity;
				incoming.cnt = byte_count;
				incoming.status = request_status(func, server_id, function_code, quantity,
					byte_count);
				status_due = {status_due, incoming};
			end
			pending <= status_due.size();
		end
	end

endmodule

>>> verif/modbus_request_validator_unit_tb.sv
`timescale 1ns / 1ps

module modbus_request_validator_unit_tb
	import mrv_pkg::*;
();

	// Number of random request items after the directed ones.
	localparam int RANDOM_ITEMS = 1300;
	// Item index at which the receiver holds off for a long stretch.
	localparam int HOLD_AT = 400;
	// Item index at which the sender waits for every status to come back.
	localparam int DRAIN_AT = 800;
	// From this item on, neither side idles.
	localparam int QUIET_FROM = 1100;
	// Length of the long receiver hold-off, in cycles.
	localparam int HOLD_CYCLES = 60;
	// Cycles with no handshake on either channel before the run is abandoned.
	localparam int WATCHDOG_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  func;
	logic [7:0]  server_id;
	logic [7:0]  function_code;
	logic [15:0] quantity;
	logic [7:0]  byte_count;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;

	int  fail_count;
	int  pending;
	int  idle_cycles;
	bit  quiet_tail;
	bit  hold_request;

	modbus_request_validator_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.server_id     (server_id),
		.function_code (function_code),
		.quantity      (quantity),
		.byte_count    (byte_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status)
	);

	// The checker sees both channels, predicts each status and compares it.
	modbus_request_validator_unit_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.server_id     (server_id),
		.function_code (function_code),
		.quantity      (quantity),
		.byte_count    (byte_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Every input of the block is known from time zero. Reset is held low at the
	// start and released on a falling edge, away from the sampling edge.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = SHAPE_NONE;
		server_id = 8'd0;
		function_code = FC_NONE;
		quantity = 16'd0;
		byte_count = 8'd0;
		quiet_tail = 1'b0;
		hold_request = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
	end

	// Receiver side. It stalls in random bursts, and once holds off for a long
	// stretch on request so that the block fills and stalls its own input.
	// Every assignment to out_stall is made on a falling edge.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 15) - 1) @(negedge clk);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// Watchdog: counts cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("watchdog expired with %0d status items outstanding", pending);
		$display("modbus_request_validator_unit: mismatch");
		$finish;
	end

	// Offers one request item, starting on a falling edge, and returns on the
	// falling edge after it was accepted. in_valid stays high on return so that
	// a following item goes out back to back.
	task automatic send_request(input logic [2:0] shape, input logic [7:0] sid,
		input logic [7:0] fc, input logic [15:0] qty, input logic [7:0] cnt);
		in_valid = 1'b1;
		func = shape;
		server_id = sid;
		function_code = fc;
		quantity = qty;
		byte_count = cnt;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// Sender gap of a given number of cycles.
	task automatic sender_gap(input int cycles);
		in_valid = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Picks a quantity around the limit of a range 1..limit: the edges on both
	// sides are likely, and so is a plain value inside the range.
	function automatic logic [15:0] pick_qty(input logic [15:0] limit);
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'd1;
			2: return limit;
			3: return limit + 16'd1;
			4: return 16'($urandom);
			default: return 16'($urandom_range(1, limit));
		endcase
	endfunction

	// One random request item. Most items are well formed: a valid server, a
	// function code that fits the shape, and quantities near their limits, so
	// that the limit and byte count checks are reached. The rest is noise over
	// every field, the unused shape code included.
	task automatic send_random();
		logic [2:0]  shape;
		logic [7:0]  sid;
		logic [7:0]  fc;
		logic [15:0] qty;
		logic [7:0]  cnt;
		shape = 3'($urandom_range(0, 7));
		sid = 8'($urandom_range(1, SERVER_ID_MAX));
		qty = 16'($urandom);
		cnt = 8'($urandom);
		if ($urandom_range(0, 19) == 0)
			sid = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(248, 255));
		if ($urandom_range(0, 9) < 3) begin
			fc = 8'($urandom);
		end else begin
			case (shape)
				SHAPE_NONE: begin
					case ($urandom_range(0, 3))
						0: fc = FC_READ_EXCEPTION;
						1: fc = FC_COMM_COUNTER;
						2: fc = FC_COMM_LOG;
						default: fc = FC_REPORT_SERVER;
					endcase
				end
				SHAPE_ONE: fc = FC_READ_FIFO;
				SHAPE_TWO: begin
					fc = 8'($urandom_range(FC_READ_COILS, FC_WRITE_REGISTER));
					if (fc == FC_READ_COILS || fc == FC_READ_DISCRETE)
						qty = pick_qty(QTY_BITS_MAX);
					else if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT)
						qty = pick_qty(QTY_REGS_MAX);
					else if (fc == FC_WRITE_COIL && $urandom_range(0, 3) != 0)
						qty = ($urandom_range(0, 1) == 0) ? 16'd0 : COIL_ON;
				end
				SHAPE_THREE: fc = FC_MASK_WRITE;
				SHAPE_WORDS: begin
					fc = FC_WRITE_REGISTERS;
					qty = pick_qty(QTY_WRITE_REG_MAX);
					if ($urandom_range(0, 3) != 0)
						cnt = 8'(qty << 1);
					else if ($urandom_range(0, 1) == 0)
						cnt = 8'(qty << 1) + 8'd1;
				end
				SHAPE_BYTES: begin
					fc = FC_WRITE_COILS;
					qty = pick_qty(QTY_WRITE_BIT_MAX);
					if ($urandom_range(0, 3) != 0)
						cnt = 8'((qty + 16'd7) >> 3);
					else if ($urandom_range(0, 1) == 0)
						cnt = 8'((qty + 16'd7) >> 3) - 8'd1;
				end
				default: fc = 8'($urandom_range(1, FC_MAX));
			endcase
		end
		send_request(shape, sid, fc, qty, cnt);
	endtask

	// Stimulus and verdict.
	initial begin
		@(posedge arst_n);
		@(negedge clk);

		// Directed items. Server boundaries: broadcast, the top valid ID and the
		// reserved range above it.
		send_request(SHAPE_NONE, 8'd0, FC_READ_EXCEPTION, 16'd0, 8'd0);
		send_request(SHAPE_NONE, 8'd248, FC_READ_EXCEPTION, 16'd0, 8'd0);
		send_request(SHAPE_NONE, 8'd255, 8'hff, 16'hffff, 8'hff);
		send_request(SHAPE_NONE, SERVER_ID_MAX, FC_READ_EXCEPTION, 16'd0, 8'd0);
		// Illegal function codes, and an unknown but legal one that passes.
		send_request(SHAPE_ONE, 8'd1, FC_NONE, 16'd0, 8'd0);
		send_request(SHAPE_ONE, 8'd1, FC_RSVD_09, 16'd0, 8'd0);
		send_request(SHAPE_ONE, 8'd1, FC_RSVD_13, 16'd0, 8'd0);
		send_request(SHAPE_ONE, 8'd1, 8'h80, 16'd0, 8'd0);
		send_request(SHAPE_THREE, 8'd1, FC_MAX, 16'd0, 8'd0);
		// A known code carried by the wrong shape gives a parameter count error;
		// the one-word and three-word shapes then carry their own codes.
		send_request(SHAPE_NONE, 8'd1, FC_READ_COILS, 16'd1, 8'd0);
		send_request(SHAPE_ONE, 8'd1, FC_READ_FIFO, 16'd0, 8'd0);
		send_request(SHAPE_THREE, 8'd1, FC_MASK_WRITE, 16'd0, 8'd0);
		// Two-word limits: both sides of each upper bound, a zero quantity and the coil values.
		send_request(SHAPE_TWO, 8'd1, FC_READ_COILS, 16'd0, 8'd0);
		send_request(SHAPE_TWO, 8'd1, FC_READ_DISCRETE, QTY_BITS_MAX, 8'd0);
		send_request(SHAPE_TWO, 8'd1, FC_READ_COILS, QTY_BITS_MAX + 16'd1, 8'd0);
		send_request(SHAPE_TWO, 8'd1, FC_READ_INPUT, QTY_REGS_MAX, 8'd0);
		send_request(SHAPE_TWO, 8'd1, FC_READ_HOLDING, QTY_REGS_MAX + 16'd1, 8'd0);
		send_request(SHAPE_TWO, 8'd1, FC_WRITE_COIL, COIL_ON, 8'd0);
		send_request(SHAPE_TWO, 8'd1, FC_WRITE_COIL, 16'd1, 8'd0);
		send_request(SHAPE_TWO, 8'd1, FC_WRITE_REGISTER, 16'hffff, 8'd0);
		// Word array: full size, over the limit, and a wrong byte count.
		send_request(SHAPE_WORDS, 8'd1, FC_WRITE_REGISTERS, QTY_WRITE_REG_MAX, 8'd246);
		send_request(SHAPE_WORDS, 8'd1, FC_WRITE_REGISTERS, QTY_WRITE_REG_MAX + 16'd1,
			8'd248);
		send_request(SHAPE_WORDS, 8'd1, FC_WRITE_REGISTERS, 16'd3, 8'd5);
		// Byte array: full size, a rounded-up count, one too few, and zero items.
		send_request(SHAPE_BYTES, 8'd1, FC_WRITE_COILS, QTY_WRITE_BIT_MAX, 8'd246);
		send_request(SHAPE_BYTES, 8'd1, FC_WRITE_COILS, 16'd9, 8'd2);
		send_request(SHAPE_BYTES, 8'd1, FC_WRITE_COILS, 16'd9, 8'd1);
		send_request(SHAPE_BYTES, 8'd1, FC_WRITE_COILS, 16'd0, 8'd0);
		// Raw shape and the unused shape code skip the parameter checks.
		send_request(SHAPE_RAW, 8'd1, FC_DIAGNOSTICS, 16'd0, 8'd0);
		send_request(SHAPE_SPARE, 8'd1, FC_READ_COILS, 16'd0, 8'hff);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == QUIET_FROM)
				quiet_tail = 1'b1;
			if (i == HOLD_AT) begin
				// Ask the receiver for a long hold-off and keep offering items
				// back to back, so that both stages fill and in_stall rises.
				hold_request = 1'b1;
				for (int j = 0; j < 20; j++)
					send_random();
			end
			if (i == DRAIN_AT) begin
				// Hold the input until every status item has come back.
				in_valid = 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
			if (!quiet_tail && $urandom_range(0, 7) == 0)
				sender_gap($urandom_range(1, 15));
			send_random();
		end
		in_valid = 1'b0;

		// Wait for the last status items, then keep the clock running to catch any
		// stray output beyond the two-stage pipeline.
		wait (pending == 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("modbus_request_validator_unit: match");
		else
			$display("modbus_request_validator_unit: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/mrv_pkg.sv
rtl/core/modbus_request_validator_unit.sv
rtl/core/mrv_checker.sv
verif/modbus_request_validator_unit_checker.sv
verif/modbus_request_validator_unit_tb.sv
